>>> hdl/gqfn_pkg.sv
// ----------------------------------------------------------------------------
// gqfn_pkg: shared types for the quad face normal pipeline
// Lane widths and the sideband record that travels beside each item.
// ----------------------------------------------------------------------------
`default_nettype none

package gqfn_pkg;

	// Width of the squared-magnitude sum and of the division remainder.
	localparam int SumW = 62;
	// Width of one squared component.
	localparam int SqW = 60;
	// Width of the quotient floor(c^2 * 2^32 / S), which may reach 2^32.
	localparam int QuoW = 33;
	// Number of quotient bits, one per division stage.
	localparam int DivSteps = 33;
	// Width of the square-root result and of its square.
	localparam int RootW = 18;
	localparam int RootSqW = 37;
	// Number of root bits, one per square-root stage.
	localparam int SqrtSteps = 18;

	typedef struct packed {
		logic       v;
		logic       degen;
		logic [2:0] neg;
	} side_t;

	typedef logic [2:0][SumW-1:0]    rem_vec_t;
	typedef logic [2:0][QuoW-1:0]    quo_vec_t;
	typedef logic [2:0][RootW-1:0]   root_vec_t;
	typedef logic [2:0][RootSqW-1:0] rsq_vec_t;
	typedef logic [2:0][SqW-1:0]     sq_vec_t;
	typedef logic [2:0][15:0]        pos_vec_t;

endpackage

`default_nettype wire

>>> hdl/gqfn_front.sv
// ----------------------------------------------------------------------------
// gqfn_front: differences, cross products, pre-scale, squares and their sum
// Six register stages from the corner positions to the squared components.
// ----------------------------------------------------------------------------
`default_nettype none

module gqfn_front
	import gqfn_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     en,
	input  wire logic     in_v,
	input  wire pos_vec_t lt,
	input  wire pos_vec_t rt,
	input  wire pos_vec_t lb,
	input  wire pos_vec_t rb,
	output side_t         side_o,
	output logic [SumW-1:0] s_o,
	output sq_vec_t       c2_o
);

	logic               v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic signed [16:0] b_s1 [3];
	logic signed [16:0] d_s1 [3];
	logic signed [33:0] pa_s2 [3];
	logic signed [33:0] pb_s2 [3];
	logic [34:0]        mag_s3 [3];
	logic [2:0]         neg_s3, neg_s4, neg_s5, neg_s6;
	logic               zero_s3, zero_s4, zero_s5, zero_s6;
	logic [29:0]        mag_s4 [3];
	logic [SqW-1:0]     sq_s5 [3];
	logic [SqW-1:0]     sq_s6 [3];
	logic [SumW-1:0]    s_s6;

	logic signed [34:0] n_c [3];
	logic [34:0]        or_c;
	logic [2:0]         k_c;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			n_c[i] = {pa_s2[i][33], pa_s2[i]} - {pb_s2[i][33], pb_s2[i]};
		end
		or_c = mag_s3[0] | mag_s3[1] | mag_s3[2];
		priority if (or_c[34]) k_c = 3'd5;
		else if (or_c[33]) k_c = 3'd4;
		else if (or_c[32]) k_c = 3'd3;
		else if (or_c[31]) k_c = 3'd2;
		else if (or_c[30]) k_c = 3'd1;
		else k_c = 3'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0; v_s2 <= 1'b0; v_s3 <= 1'b0;
			v_s4 <= 1'b0; v_s5 <= 1'b0; v_s6 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_v; v_s2 <= v_s1; v_s3 <= v_s2;
			v_s4 <= v_s3; v_s5 <= v_s4; v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				b_s1[i] <= $signed({lb[i][15], lb[i]}) - $signed({rt[i][15], rt[i]});
				d_s1[i] <= $signed({rb[i][15], rb[i]}) - $signed({lt[i][15], lt[i]});
			end
			for (int i = 0; i < 3; i++) begin
				pa_s2[i] <= b_s1[(i + 2) % 3] * d_s1[(i + 1) % 3];
				pb_s2[i] <= b_s1[(i + 1) % 3] * d_s1[(i + 2) % 3];
			end
			for (int i = 0; i < 3; i++) begin
				neg_s3[i] <= n_c[i][34];
				mag_s3[i] <= n_c[i][34] ? 35'(-n_c[i]) : 35'(n_c[i]);
			end
			zero_s3 <= (n_c[0] == '0) && (n_c[1] == '0) && (n_c[2] == '0);
			for (int i = 0; i < 3; i++) begin
				mag_s4[i] <= 30'(mag_s3[i] >> k_c);
			end
			neg_s4 <= neg_s3; zero_s4 <= zero_s3;
			for (int i = 0; i < 3; i++) begin
				sq_s5[i] <= mag_s4[i] * mag_s4[i];
			end
			neg_s5 <= neg_s4; zero_s5 <= zero_s4;
			for (int i = 0; i < 3; i++) begin
				sq_s6[i] <= sq_s5[i];
			end
			s_s6 <= SumW'(sq_s5[0]) + SumW'(sq_s5[1]) + SumW'(sq_s5[2]);
			neg_s6 <= neg_s5; zero_s6 <= zero_s5;
		end
	end

	assign side_o = '{v: v_s6, degen: zero_s6, neg: neg_s6};
	assign s_o    = s_s6;
	assign c2_o   = {sq_s6[2], sq_s6[1], sq_s6[0]};

endmodule

`default_nettype wire

>>> hdl/gqfn_div_step.sv
// ----------------------------------------------------------------------------
// gqfn_div_step: one restoring division stage for the three lanes
// Produces one quotient bit of floor(c^2 * 2^32 / S) per lane.
// ----------------------------------------------------------------------------
`default_nettype none

module gqfn_div_step
	import gqfn_pkg::*;
#(
	parameter bit FIRST = 1'b0
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            en,
	input  wire side_t           side_i,
	input  wire logic [SumW-1:0] s_i,
	input  wire rem_vec_t        rem_i,
	input  wire quo_vec_t        q_i,
	output side_t                side_s1,
	output logic [SumW-1:0]      s_s1,
	output rem_vec_t             rem_s1,
	output quo_vec_t             q_s1
);

	logic [SumW:0] sh_c [3];
	logic [2:0]    ge_c;
	logic [SumW:0] dif_c [3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			// The first stage yields the integer bit and compares unshifted.
			sh_c[i]  = FIRST ? {1'b0, rem_i[i]} : {rem_i[i], 1'b0};
			ge_c[i]  = sh_c[i] >= {1'b0, s_i};
			dif_c[i] = sh_c[i] - {1'b0, s_i};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_s1 <= '0;
		end else if (en) begin
			side_s1 <= side_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			s_s1 <= s_i;
			for (int i = 0; i < 3; i++) begin
				rem_s1[i] <= ge_c[i] ? dif_c[i][SumW-1:0] : sh_c[i][SumW-1:0];
				q_s1[i]   <= {q_i[i][QuoW-2:0], ge_c[i]};
			end
		end
	end

endmodule

`default_nettype wire

>>> hdl/gqfn_sqrt_step.sv
// ----------------------------------------------------------------------------
// gqfn_sqrt_step: one digit-by-digit integer square root stage
// Decides root bit BIT for the three lanes, keeping the root's square.
// ----------------------------------------------------------------------------
`default_nettype none

module gqfn_sqrt_step
	import gqfn_pkg::*;
#(
	parameter int BIT = 17
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      en,
	input  wire side_t     side_i,
	input  wire quo_vec_t  f_i,
	input  wire root_vec_t r_i,
	input  wire rsq_vec_t  r2_i,
	output side_t          side_s1,
	output quo_vec_t       f_s1,
	output root_vec_t      r_s1,
	output rsq_vec_t       r2_s1
);

	logic [RootSqW-1:0] t2_c [3];
	logic [2:0]         take_c;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			// (r + 2^b)^2 = r^2 + r * 2^(b+1) + 2^(2b), as r has no bits at or below b.
			t2_c[i] = r2_i[i] + (RootSqW'(r_i[i]) << (BIT + 1))
				+ (RootSqW'(1) << (2 * BIT));
			take_c[i] = t2_c[i] <= RootSqW'(f_i[i]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_s1 <= '0;
		end else if (en) begin
			side_s1 <= side_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				f_s1[i]  <= f_i[i];
				r_s1[i]  <= take_c[i] ? (r_i[i] | (RootW'(1) << BIT)) : r_i[i];
				r2_s1[i] <= take_c[i] ? t2_c[i] : r2_i[i];
			end
		end
	end

endmodule

`default_nettype wire

>>> hdl/grid_quad_face_normal_core.sv
// ----------------------------------------------------------------------------
// grid_quad_face_normal_core: unit face normal of one cloth grid quad
// Cross products, pre-scale, per-lane division and square root, rounding.
// ----------------------------------------------------------------------------
// The block takes the four Q8.8 corners of a quad and returns the unit normal
// of cross(rb-rt, lb-rt) + cross(lb-rt, lt-rt) in Q1.15, with a degenerate
// flag when that sum is the zero vector. It is a fully pipelined datapath that
// accepts one transfer per clock unless stalled, passing each input through
// six front stages (differences, products, magnitudes,
// pre-scale, squares, sum), 33 restoring division stages that each decide one
// quotient bit of c^2 * 2^32 / S, 18 square-root stages that each decide one
// root bit, and a rounding output register. The whole pipeline advances as
// one unit; it holds only while a finished result sits on the output and the
// receiver stalls it, so in_stall is exactly that condition.
`default_nettype none

module grid_quad_face_normal_core
	import gqfn_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [15:0] left_top_x,
	input  wire logic [15:0] left_top_y,
	input  wire logic [15:0] left_top_z,
	input  wire logic [15:0] right_top_x,
	input  wire logic [15:0] right_top_y,
	input  wire logic [15:0] right_top_z,
	input  wire logic [15:0] left_bottom_x,
	input  wire logic [15:0] left_bottom_y,
	input  wire logic [15:0] left_bottom_z,
	input  wire logic [15:0] right_bottom_x,
	input  wire logic [15:0] right_bottom_y,
	input  wire logic [15:0] right_bottom_z,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [15:0]      normal_x,
	output logic [15:0]      normal_y,
	output logic [15:0]      normal_z,
	output logic             degenerate
);

	// Every stage moves forward unless a result is waiting and stalled.
	logic adv;
	assign adv      = !(out_valid && out_stall);
	assign in_stall = !adv;

	side_t           front_side;
	logic [SumW-1:0] front_s;
	sq_vec_t         front_c2;

	gqfn_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (adv),
		.in_v   (in_valid),
		.lt     ({left_top_z, left_top_y, left_top_x}),
		.rt     ({right_top_z, right_top_y, right_top_x}),
		.lb     ({left_bottom_z, left_bottom_y, left_bottom_x}),
		.rb     ({right_bottom_z, right_bottom_y, right_bottom_x}),
		.side_o (front_side),
		.s_o    (front_s),
		.c2_o   (front_c2)
	);

	// Division chain. Entry 0 is the front output; entry k is after k stages.
	side_t           div_side [DivSteps+1];
	logic [SumW-1:0] div_s    [DivSteps+1];
	rem_vec_t        div_rem  [DivSteps+1];
	quo_vec_t        div_q    [DivSteps+1];

	assign div_side[0] = front_side;
	assign div_s[0]    = front_s;
	assign div_rem[0]  = {SumW'(front_c2[2]), SumW'(front_c2[1]), SumW'(front_c2[0])};
	assign div_q[0]    = '0;

	for (genvar k = 0; k < DivSteps; k++) begin : g_div
		gqfn_div_step #(.FIRST(k == 0)) u_step (
			.clk     (clk),
			.arst_n  (arst_n),
			.en      (adv),
			.side_i  (div_side[k]),
			.s_i     (div_s[k]),
			.rem_i   (div_rem[k]),
			.q_i     (div_q[k]),
			.side_s1 (div_side[k+1]),
			.s_s1    (div_s[k+1]),
			.rem_s1  (div_rem[k+1]),
			.q_s1    (div_q[k+1])
		);
	end

	// Square-root chain, most significant root bit first.
	side_t     sq_side [SqrtSteps+1];
	quo_vec_t  sq_f    [SqrtSteps+1];
	root_vec_t sq_r    [SqrtSteps+1];
	rsq_vec_t  sq_r2   [SqrtSteps+1];

	assign sq_side[0] = div_side[DivSteps];
	assign sq_f[0]    = div_q[DivSteps];
	assign sq_r[0]    = '0;
	assign sq_r2[0]   = '0;

	for (genvar j = 0; j < SqrtSteps; j++) begin : g_sqrt
		gqfn_sqrt_step #(.BIT(SqrtSteps - 1 - j)) u_step (
			.clk     (clk),
			.arst_n  (arst_n),
			.en      (adv),
			.side_i  (sq_side[j]),
			.f_i     (sq_f[j]),
			.r_i     (sq_r[j]),
			.r2_i    (sq_r2[j]),
			.side_s1 (sq_side[j+1]),
			.f_s1    (sq_f[j+1]),
			.r_s1    (sq_r[j+1]),
			.r2_s1   (sq_r2[j+1])
		);
	end

	// Round to nearest by halving root+1, then apply the sign and clamp.
	side_t          last_side;
	logic [RootW:0] inc_c [3];
	logic [15:0]    comp_c [3];

	assign last_side = sq_side[SqrtSteps];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			inc_c[i] = {1'b0, sq_r[SqrtSteps][i]} + (RootW+1)'(1);
			if (last_side.degen) begin
				comp_c[i] = '0;
			end else if (last_side.neg[i]) begin
				// Magnitude never exceeds one, so -1.0 is the lowest value.
				comp_c[i] = (inc_c[i][RootW:16] != '0) ? 16'h8000
					: 16'(-inc_c[i][16:1]);
			end else begin
				comp_c[i] = (inc_c[i][RootW:16] != '0) ? 16'h7fff
					: 16'(inc_c[i][16:1]);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (adv) begin
			out_valid <= last_side.v;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			normal_x   <= comp_c[0];
			normal_y   <= comp_c[1];
			normal_z   <= comp_c[2];
			degenerate <= last_side.degen;
		end
	end

	// A degenerate result carries an all-zero normal.
	a_degen_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && degenerate |-> normal_x == '0 && normal_y == '0 && normal_z == '0)
		else $error("degenerate result with nonzero normal");

	// A proper normal always has at least one nonzero component.
	a_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !degenerate |-> normal_x != '0 || normal_y != '0 || normal_z != '0)
		else $error("non-degenerate result has zero normal");

	// Since c^2 never exceeds S, every quotient is at most 2^32.
	a_quo_bound: assert property (@(posedge clk) disable iff (!arst_n)
		sq_side[0].v && !sq_side[0].degen |->
			sq_f[0][0] <= 33'h1_0000_0000 && sq_f[0][1] <= 33'h1_0000_0000
			&& sq_f[0][2] <= 33'h1_0000_0000)
		else $error("division quotient out of range");

endmodule

`default_nettype wire

>>> verif/tb_grid_quad_face_normal_core.sv
// ----------------------------------------------------------------------------
// tb_grid_quad_face_normal_core: self-checking bench for the quad normal core
// Drives quad corners through a valid/stall channel, predicts each unit normal
// with an independent fixed-point model and compares every output transfer.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_grid_quad_face_normal_core;
	timeunit 1ns;
	timeprecision 1ps;

	// One quad: corners in the order lt, rt, lb, rb, each as x, y, z.
	typedef struct {
		logic [15:0] c [12];
	} quad_t;

	// One unit normal as it should appear on the output.
	typedef struct {
		logic [15:0] nx;
		logic [15:0] ny;
		logic [15:0] nz;
		logic        degen;
	} normal_t;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	logic [15:0] corner [12];
	logic out_valid;
	logic out_stall;
	logic [15:0] normal_x, normal_y, normal_z;
	logic degenerate;

	quad_t   quad_q [$];
	normal_t normal_q [$];
	int      send_idle_pct;
	int      recv_stall_pct;
	bit      stim_done;
	int      n_sent, n_recv, n_degen, n_errors;

	grid_quad_face_normal_core dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.left_top_x     (corner[0]),
		.left_top_y     (corner[1]),
		.left_top_z     (corner[2]),
		.right_top_x    (corner[3]),
		.right_top_y    (corner[4]),
		.right_top_z    (corner[5]),
		.left_bottom_x  (corner[6]),
		.left_bottom_y  (corner[7]),
		.left_bottom_z  (corner[8]),
		.right_bottom_x (corner[9]),
		.right_bottom_y (corner[10]),
		.right_bottom_z (corner[11]),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.normal_x       (normal_x),
		.normal_y       (normal_y),
		.normal_z       (normal_z),
		.degenerate     (degenerate)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Floor of the square root of a value below 2^36, decided bit by bit.
	function automatic longint unsigned root_floor(longint unsigned f);
		longint unsigned r, t;
		r = 0;
		for (int b = 17; b >= 0; b--) begin
			t = r | (64'd1 << b);
			if (t * t <= f) r = t;
		end
		return r;
	endfunction

	// Computes the expected unit normal of one quad.
	function automatic normal_t quad_normal(quad_t q);
		normal_t res;
		longint a [3], b [3], e [3], n [3];
		longint unsigned mag [3], mx, s, sq, quo, rem, rnd;
		bit neg [3];
		logic [15:0] comp [3];
		for (int i = 0; i < 3; i++) begin
			a[i] = longint'($signed(q.c[9+i])) - longint'($signed(q.c[3+i]));
			b[i] = longint'($signed(q.c[6+i])) - longint'($signed(q.c[3+i]));
			e[i] = longint'($signed(q.c[i])) - longint'($signed(q.c[3+i]));
		end
		n[0] = (a[1]*b[2] - a[2]*b[1]) + (b[1]*e[2] - b[2]*e[1]);
		n[1] = (a[2]*b[0] - a[0]*b[2]) + (b[2]*e[0] - b[0]*e[2]);
		n[2] = (a[0]*b[1] - a[1]*b[0]) + (b[0]*e[1] - b[1]*e[0]);
		if (n[0] == 0 && n[1] == 0 && n[2] == 0) begin
			res = '{16'd0, 16'd0, 16'd0, 1'b1};
			return res;
		end
		mx = 0;
		for (int i = 0; i < 3; i++) begin
			neg[i] = n[i] < 0;
			mag[i] = neg[i] ? longint'(-n[i]) : longint'(n[i]);
			if (mag[i] > mx) mx = mag[i];
		end
		// Bring the largest magnitude under 2^30 so the squares fit.
		while (mx >= (64'd1 << 30)) begin
			for (int i = 0; i < 3; i++) mag[i] >>= 1;
			mx >>= 1;
		end
		s = mag[0]*mag[0] + mag[1]*mag[1] + mag[2]*mag[2];
		for (int i = 0; i < 3; i++) begin
			// Long division for floor(c^2 * 2^32 / S); the quotient is at most 2^32.
			sq = mag[i] * mag[i];
			quo = sq / s;
			rem = sq % s;
			for (int k = 0; k < 32; k++) begin
				rem <<= 1;
				quo <<= 1;
				if (rem >= s) begin
					rem -= s;
					quo |= 1;
				end
			end
			rnd = (root_floor(quo) + 1) >> 1;
			if (neg[i]) comp[i] = (rnd > 32768) ? 16'h8000 : 16'(-longint'(rnd));
			else comp[i] = (rnd > 32767) ? 16'h7fff : 16'(rnd);
		end
		res = '{comp[0], comp[1], comp[2], 1'b0};
		return res;
	endfunction

	// Driver: presents the next queued quad and holds it until the transfer.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			foreach (corner[i]) corner[i] <= '0;
		end else if (!in_valid || !in_stall) begin
			if (in_valid) begin
				normal_q = {normal_q, quad_normal(quad_q.pop_front())};
				n_sent++;
			end
			if (quad_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
				in_valid <= 1'b1;
				foreach (corner[i]) corner[i] <= quad_q[0].c[i];
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Monitor: checks each output transfer and picks the next stall value.
	always @(posedge clk or negedge arst_n) begin
		normal_t want;
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				n_recv++;
				if (normal_q.size() == 0) begin
					n_errors++;
					if (n_errors <= 10)
						$display("ERROR: unexpected normal %h %h %h degen %b",
							normal_x, normal_y, normal_z, degenerate);
				end else begin
					want = normal_q.pop_front();
					if (want.degen) n_degen++;
					if (normal_x !== want.nx || normal_y !== want.ny ||
					    normal_z !== want.nz || degenerate !== want.degen) begin
						n_errors++;
						if (n_errors <= 10)
							$display("ERROR: normal %h %h %h degen %b, expected %h %h %h degen %b",
								normal_x, normal_y, normal_z, degenerate,
								want.nx, want.ny, want.nz, want.degen);
					end
				end
			end
			out_stall <= ($urandom_range(99) < recv_stall_pct);
		end
	end

	function automatic quad_t rand_quad(int kind);
		quad_t q;
		logic [15:0] base, step;
		for (int i = 0; i < 12; i++) q.c[i] = 16'($urandom);
		case (kind)
			// A small grid cell around a random origin, as cloth meshes look.
			0: begin
				for (int i = 0; i < 3; i++) begin
					base = 16'($urandom);
					q.c[i]   = base + 16'($urandom_range(0, 255)) - 16'd128;
					q.c[3+i] = base + 16'($urandom_range(0, 255)) - 16'd128;
					q.c[6+i] = base + 16'($urandom_range(0, 255)) - 16'd128;
					q.c[9+i] = base + 16'($urandom_range(0, 255)) - 16'd128;
				end
			end
			// Quads flat in a coordinate plane, or with all corners equal, which gives a zero sum.
			1: begin
				step = 16'($urandom_range(0, 3));
				for (int i = 0; i < 12; i += 3) q.c[i+step%3] = 16'd0;
				if ($urandom_range(1) == 1)
					for (int i = 0; i < 12; i++) q.c[i] = q.c[i%3];
			end
			// Corner values drawn from 8000, 7fff, 0000 and ffff only.
			2: begin
				for (int i = 0; i < 12; i++)
					case ($urandom_range(3))
						0: q.c[i] = 16'h8000;
						1: q.c[i] = 16'h7fff;
						2: q.c[i] = 16'h0000;
						default: q.c[i] = 16'hffff;
					endcase
			end
			default: ;
		endcase
		return q;
	endfunction

	initial begin
		quad_t q;
		n_sent = 0;
		n_recv = 0;
		n_degen = 0;
		n_errors = 0;
		stim_done = 1'b0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		arst_n = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: all-zero, all-equal, flat in each plane, the extremes and bit patterns.
		foreach (q.c[i]) q.c[i] = 16'h0000;
		quad_q = {quad_q, q};
		foreach (q.c[i]) q.c[i] = 16'h7fff;
		quad_q = {quad_q, q};
		// Unit square in the xy plane, then in yz and zx.
		for (int p = 0; p < 3; p++) begin
			foreach (q.c[i]) q.c[i] = 16'h0000;
			q.c[3+p] = 16'h0100;
			q.c[6+(p+1)%3] = 16'h0100;
			q.c[9+p] = 16'h0100;
			q.c[9+(p+1)%3] = 16'h0100;
			quad_q = {quad_q, q};
			// Mirrored so each axis also comes out negative.
			q.c[3+p] = 16'hff00;
			q.c[9+p] = 16'hff00;
			quad_q = {quad_q, q};
		end
		// Largest spans, so the pre-scale shifts the most.
		for (int k = 0; k < 8; k++) begin
			for (int i = 0; i < 12; i++)
				q.c[i] = ((i + k) % 2 == 0) ? 16'h8000 : 16'h7fff;
			q.c[k] = 16'h0000;
			quad_q = {quad_q, q};
		end
		// Normal exactly along minus one axis, where -1.0 must not clamp.
		foreach (q.c[i]) q.c[i] = 16'h0000;
		q.c[3] = 16'h8000;
		q.c[7] = 16'h7fff;
		q.c[9] = 16'h8000;
		q.c[10] = 16'h7fff;
		quad_q = {quad_q, q};
		// Alternating bit patterns drive most corner inputs to both 5555 and aaaa.
		foreach (q.c[i]) q.c[i] = 16'h5555;
		q.c[4] = 16'haaaa;
		q.c[8] = 16'haaaa;
		quad_q = {quad_q, q};
		foreach (q.c[i]) q.c[i] = 16'haaaa;
		q.c[1] = 16'h5555;
		q.c[11] = 16'h5555;
		quad_q = {quad_q, q};

		// Random phases, each with a different idling pattern.
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 65; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 65; end
				default: begin send_idle_pct = 37; recv_stall_pct = 37; end
			endcase
			for (int k = 0; k < 200; k++) begin
				if ($urandom_range(99) < 55) quad_q = {quad_q, rand_quad(0)};
				else quad_q = {quad_q, rand_quad($urandom_range(1, 3))};
			end
			while (quad_q.size() > 0) @(posedge clk);
		end
		send_idle_pct = 0;
		recv_stall_pct = 0;
		// Let the last transfer land before the drain starts.
		@(posedge clk);
		while (in_valid) @(posedge clk);
		while (normal_q.size() > 0) @(posedge clk);
		// Any output beyond the expected normals would show up here.
		repeat (100) @(posedge clk);
		$display("Sent %0d quads and checked %0d normals (%0d degenerate),",
			n_sent, n_recv, n_degen);
		$display("under free flow, sender gaps, receiver stalls and both.");
		if (n_errors == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("%0d mismatches", n_errors);
			$display("CHECKS FAILED");
		end
		$finish;
	end

	initial begin
		#2ms;
		$display("Timeout with %0d normals outstanding", normal_q.size());
		$display("CHECKS FAILED");
		$finish;
	end

endmodule

`default_nettype wire
